FILE: rtl/core/rid_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the combinational word decoder for the instruction decoder.
// Depends on nothing; imported by the interfaces' users and the top level.
package rid_pkg;

  localparam logic [5:0] OP_XMEM = 6'd0;
  localparam logic [5:0] OP_LD   = 6'd1;
  localparam logic [5:0] OP_AND  = 6'd4;
  localparam logic [5:0] OP_ADDU = 6'd8;
  localparam logic [5:0] OP_CLR  = 6'd16;
  localparam logic [5:0] OP_TB0  = 6'd22;
  localparam logic [5:0] OP_TB1  = 6'd23;
  localparam logic [5:0] OP_TCND = 6'd24;
  localparam logic [5:0] OP_BR   = 6'd25;
  localparam logic [5:0] OP_LDCR = 6'd29;
  localparam logic [5:0] OP_STCR = 6'd30;
  localparam logic [5:0] OP_XCR  = 6'd31;
  localparam logic [5:0] OP_FMUL = 6'd32;
  localparam logic [5:0] OP_FLT  = 6'd33;
  localparam logic [5:0] OP_FADD = 6'd34;
  localparam logic [5:0] OP_FSUB = 6'd35;
  localparam logic [5:0] OP_FCMP = 6'd36;
  localparam logic [5:0] OP_INT  = 6'd37;
  localparam logic [5:0] OP_FDIV = 6'd40;
  localparam logic [5:0] OP_BCND = 6'd41;
  localparam logic [5:0] OP_TBND = 6'd42;
  localparam logic [5:0] OP_JMP  = 6'd43;
  localparam logic [5:0] OP_JSR  = 6'd44;
  localparam logic [5:0] OP_FF0  = 6'd45;
  localparam logic [5:0] OP_FF1  = 6'd46;
  localparam logic [5:0] OP_RTE  = 6'd47;

  localparam logic [2:0] SIZE_WORD   = 3'd0;
  localparam logic [2:0] SIZE_DOUBLE = 3'd1;
  localparam logic [2:0] SIZE_HALF   = 3'd2;
  localparam logic [2:0] SIZE_BYTE   = 3'd3;
  localparam logic [2:0] SIZE_UBYTE  = 3'd4;
  localparam logic [2:0] SIZE_UHALF  = 3'd5;

  localparam logic [7:0] FLAG_USER  = 8'h01;
  localparam logic [7:0] FLAG_U     = 8'h02;
  localparam logic [7:0] FLAG_C     = 8'h04;
  localparam logic [7:0] FLAG_CI    = 8'h08;
  localparam logic [7:0] FLAG_CO    = 8'h10;
  localparam logic [7:0] FLAG_N     = 8'h20;
  localparam logic [7:0] FLAG_FPU   = 8'h40;
  localparam logic [7:0] FLAG_IDX   = 8'h80;

  localparam logic [4:0] FORM_NONE      = 5'd0;
  localparam logic [4:0] FORM_RD_RS1_IMM = 5'd1;
  localparam logic [4:0] FORM_RD_RS1_RS2 = 5'd2;
  localparam logic [4:0] FORM_RD_INDEX  = 5'd3;
  localparam logic [4:0] FORM_RD_RS2    = 5'd4;
  localparam logic [4:0] FORM_RS1_IMM   = 5'd5;
  localparam logic [4:0] FORM_RS1_RS2   = 5'd6;
  localparam logic [4:0] FORM_RS2       = 5'd7;
  localparam logic [4:0] FORM_BIT_DISP  = 5'd8;
  localparam logic [4:0] FORM_COND_DISP = 5'd9;
  localparam logic [4:0] FORM_DISP26    = 5'd10;
  localparam logic [4:0] FORM_RD_CR     = 5'd11;
  localparam logic [4:0] FORM_RS1_CR    = 5'd12;
  localparam logic [4:0] FORM_RD_RS1_CR = 5'd13;
  localparam logic [4:0] FORM_FIELD     = 5'd14;
  localparam logic [4:0] FORM_BIT_VEC   = 5'd15;
  localparam logic [4:0] FORM_COND_VEC  = 5'd16;

  typedef struct packed {
    logic        legal;
    logic [5:0]  operation;
    logic [2:0]  size_code;
    logic [7:0]  modifier_flags;
    logic [2:0]  float_precisions;
    logic [4:0]  operand_form;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [15:0] immediate;
    logic        tgt_en;
    logic [31:0] disp;
  } dec_t;

  // register use per form: bit0 rd, bit1 rs1, bit2 rs2
  function automatic logic [2:0] form_use(input logic [4:0] form);
    logic [2:0] u;
    case (form)
      FORM_RD_RS1_IMM, FORM_BIT_DISP, FORM_COND_DISP, FORM_RD_RS1_CR,
      FORM_FIELD, FORM_BIT_VEC, FORM_COND_VEC:  u = 3'b011;
      FORM_RD_RS1_RS2, FORM_RD_INDEX:           u = 3'b111;
      FORM_RD_RS2:                              u = 3'b101;
      FORM_RS1_IMM, FORM_RS1_CR:                u = 3'b010;
      FORM_RS1_RS2:                             u = 3'b110;
      FORM_RS2:                                 u = 3'b100;
      FORM_RD_CR:                               u = 3'b001;
      default:                                  u = 3'b000;
    endcase
    return u;
  endfunction

  // {operation, size} for the load/store/xmem group
  function automatic logic [8:0] mem_size(input logic [1:0] p, input logic [1:0] ty);
    logic [5:0] op;
    logic [2:0] sz;
    op = {4'd0, p};
    case (ty)
      2'd0:    sz = SIZE_DOUBLE;
      2'd1:    sz = SIZE_WORD;
      2'd2:    sz = SIZE_HALF;
      default: sz = SIZE_BYTE;
    endcase
    if (p == 2'd0) begin
      if (ty[1]) begin
        op = OP_LD;
      end
      case (ty)
        2'd0:    sz = SIZE_UBYTE;
        2'd1:    sz = SIZE_WORD;
        2'd2:    sz = SIZE_UHALF;
        default: sz = SIZE_UBYTE;
      endcase
    end
    return {op, sz};
  endfunction

  function automatic dec_t rid_decode(input logic [31:0] w);
    dec_t       d;
    logic       ok;
    logic       chk;
    logic [2:0] maj;
    logic [2:0] mn;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic [2:0] sub;
    logic [2:0] u;
    logic [8:0] ms;
    d   = '0;
    ok  = 1'b0;
    chk = 1'b0;
    maj = w[31:29];
    mn  = w[28:26];
    rd  = w[25:21];
    rs1 = w[20:16];
    rs2 = w[4:0];
    sub = 3'd0;
    ms  = 9'd0;
    unique case (maj)
      3'd0, 3'd1: begin
        if (w[29:28] != 2'd3) begin
          ms = mem_size(w[29:28], w[27:26]);
          d.operation = ms[8:3];
          d.size_code = ms[2:0];
          d.operand_form = FORM_RD_RS1_IMM;
          d.immediate = w[15:0];
          ok = 1'b1;
        end
      end
      3'd2: begin
        d.operation = OP_AND + {4'd0, mn[2:1]};
        if (mn[0]) d.modifier_flags = FLAG_U;
        d.operand_form = FORM_RD_RS1_IMM;
        d.immediate = w[15:0];
        ok = 1'b1;
      end
      3'd3: begin
        d.operation = OP_ADDU + {3'd0, mn};
        d.operand_form = FORM_RD_RS1_IMM;
        d.immediate = w[15:0];
        ok = 1'b1;
      end
      3'd4: begin
        if (mn == 3'd0) begin
          if (w[15:14] != 2'd0 && w[13:11] <= 3'd1) begin
            if (w[11]) d.modifier_flags = FLAG_FPU;
            d.immediate = {10'd0, w[10:5]};
            case (w[15:14])
              2'd1: begin
                d.operation = OP_LDCR;
                d.operand_form = FORM_RD_CR;
                ok = (rs1 == 5'd0) && (rs2 == 5'd0);
              end
              2'd2: begin
                d.operation = OP_STCR;
                d.operand_form = FORM_RS1_CR;
                ok = (rd == 5'd0);
              end
              default: begin
                d.operation = OP_XCR;
                d.operand_form = FORM_RD_RS1_CR;
                ok = 1'b1;
              end
            endcase
          end
        end else if (mn == 3'd1) begin
          if (w[10] == 1'b0 && w[8] == 1'b0 && w[6] == 1'b0) begin
            d.float_precisions = {w[7], w[9], w[5]};
            d.operand_form = FORM_RD_RS1_RS2;
            case (w[15:11])
              5'd7: begin
                d.operation = OP_FCMP;
                ok = !w[5];
              end
              5'd0: begin
                d.operation = OP_FMUL;
                ok = 1'b1;
              end
              5'd5: begin
                d.operation = OP_FADD;
                ok = 1'b1;
              end
              5'd6: begin
                d.operation = OP_FSUB;
                ok = 1'b1;
              end
              5'd14: begin
                d.operation = OP_FDIV;
                ok = 1'b1;
              end
              5'd4: begin
                d.operation = OP_FLT;
                chk = !w[7];
              end
              5'd9, 5'd10, 5'd11: begin
                d.operation = OP_INT + {4'd0, w[12:11] - 2'd1};
                chk = !w[5];
              end
              default: ok = 1'b0;
            endcase
            if (chk) begin
              d.operand_form = FORM_RD_RS2;
              ok = (rs1 == 5'd0) && !w[9];
            end
          end
        end
      end
      3'd6: begin
        d.operation = OP_BR + {4'd0, mn[2:1]};
        if (mn[0]) d.modifier_flags = FLAG_N;
        d.tgt_en = 1'b1;
        if (mn[2]) begin
          d.operand_form = FORM_BIT_DISP;
          d.disp = {{14{w[15]}}, w[15:0], 2'b00};
        end else begin
          d.operand_form = FORM_DISP26;
          d.disp = {{4{w[25]}}, w[25:0], 2'b00};
        end
        ok = 1'b1;
      end
      3'd7: begin
        case (mn)
          3'd2, 3'd3: begin
            d.operation = OP_BCND;
            if (mn[0]) d.modifier_flags = FLAG_N;
            d.operand_form = FORM_COND_DISP;
            d.tgt_en = 1'b1;
            d.disp = {{14{w[15]}}, w[15:0], 2'b00};
            ok = 1'b1;
          end
          3'd4: begin
            d.immediate = {6'd0, w[9:0]};
            if (!w[10]) begin
              if (w[15:14] == 2'd2 && w[13:11] <= 3'd5) begin
                d.operation = OP_CLR + {3'd0, w[13:11]};
                d.operand_form = FORM_FIELD;
                ok = 1'b1;
              end else if (w[15:14] == 2'd3) begin
                case (w[13:11])
                  3'd2: begin
                    d.operation = OP_TB0;
                    d.operand_form = FORM_BIT_VEC;
                    ok = 1'b1;
                  end
                  3'd3: begin
                    d.operation = OP_TB1;
                    d.operand_form = FORM_BIT_VEC;
                    ok = 1'b1;
                  end
                  3'd5: begin
                    d.operation = OP_TCND;
                    d.operand_form = FORM_COND_VEC;
                    ok = 1'b1;
                  end
                  default: ok = 1'b0;
                endcase
              end
            end
          end
          3'd5: begin
            case (w[15:13])
              3'd0, 3'd1: begin
                if (!((w[13:12] == 2'd3) && (!w[9] || w[8])) && w[7:5] == 3'd0) begin
                  ms = mem_size(w[13:12], w[11:10]);
                  d.operation = ms[8:3];
                  d.size_code = ms[2:0];
                  if (w[8]) d.modifier_flags = FLAG_USER;
                  if (w[9]) begin
                    d.modifier_flags = d.modifier_flags | FLAG_IDX;
                    d.operand_form = FORM_RD_INDEX;
                  end else begin
                    d.operand_form = FORM_RD_RS1_RS2;
                  end
                  ok = 1'b1;
                end
              end
              3'd2: begin
                if (w[9:5] == 5'd0 && w[12:11] != 2'd1) begin
                  if (w[10]) d.modifier_flags = FLAG_C;
                  d.operation = OP_AND + {4'd0, w[12:11]};
                  d.operand_form = FORM_RD_RS1_RS2;
                  ok = 1'b1;
                end
              end
              3'd3: begin
                sub = w[12:10];
                if (w[7:5] == 3'd0) begin
                  if (sub[1]) begin
                    ok = !w[9];
                  end else begin
                    if (w[9]) d.modifier_flags = FLAG_CI;
                    if (w[8]) d.modifier_flags = d.modifier_flags | FLAG_CO;
                    ok = 1'b1;
                  end
                  d.operation = OP_ADDU + {3'd0, sub};
                  d.operand_form = FORM_RD_RS1_RS2;
                end
              end
              3'd4, 3'd5: begin
                if (w[10:5] == 6'd0 && w[13:11] <= 3'd5) begin
                  d.operation = OP_CLR + {3'd0, w[13:11]};
                  d.operand_form = FORM_RD_RS1_RS2;
                  ok = 1'b1;
                end
              end
              3'd6: begin
                if (rd == 5'd0 && rs1 == 5'd0 && w[9:5] == 5'd0) begin
                  d.operation = w[11] ? OP_JSR : OP_JMP;
                  if (w[10]) d.modifier_flags = FLAG_N;
                  d.operand_form = FORM_RS2;
                  ok = 1'b1;
                end
              end
              default: begin
                sub = w[12:10];
                if (w[9:5] == 5'd0) begin
                  case (sub)
                    3'd2, 3'd3: begin
                      d.operation = w[10] ? OP_FF0 : OP_FF1;
                      d.operand_form = FORM_RD_RS2;
                      ok = (rs1 == 5'd0);
                    end
                    3'd6: begin
                      d.operation = OP_TBND;
                      d.operand_form = FORM_RS1_RS2;
                      ok = (rd == 5'd0);
                    end
                    3'd7: begin
                      d.operation = OP_RTE;
                      d.operand_form = FORM_NONE;
                      ok = (rd == 5'd0) && (rs1 == 5'd0) && (rs2 == 5'd0);
                    end
                    default: ok = 1'b0;
                  endcase
                end
              end
            endcase
          end
          3'd6: begin
            d.operation = OP_TBND;
            d.operand_form = FORM_RS1_IMM;
            d.immediate = w[15:0];
            ok = (rd == 5'd0);
          end
          default: ok = 1'b0;
        endcase
      end
      default: ok = 1'b0;
    endcase
    u = form_use(d.operand_form);
    d.dest_reg = u[0] ? rd : 5'd0;
    d.src1_reg = u[1] ? rs1 : 5'd0;
    d.src2_reg = u[2] ? rs2 : 5'd0;
    d.legal = 1'b1;
    if (!ok) begin
      d = '0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/rid_in_if.sv
`timescale 1ns / 1ps
// Input channel of the instruction decoder: valid/ready plus the word and its next address.
// Standalone; no package needed.
interface rid_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [31:0] next_address;

  modport source (output valid, output instruction_word, output next_address, input ready);
  modport sink (input valid, input instruction_word, input next_address, output ready);
endinterface

FILE: rtl/core/rid_out_if.sv
`timescale 1ns / 1ps
// Output channel of the instruction decoder: valid/ready plus the decoded fields.
// Standalone; no package needed.
interface rid_out_if;
  logic        valid;
  logic        ready;
  logic        legal;
  logic [5:0]  operation;
  logic [2:0]  size_code;
  logic [7:0]  modifier_flags;
  logic [2:0]  float_precisions;
  logic [4:0]  operand_form;
  logic [4:0]  dest_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  src2_reg;
  logic [15:0] immediate;
  logic [31:0] branch_target;

  modport source (output valid, output legal, output operation, output size_code,
                  output modifier_flags, output float_precisions, output operand_form,
                  output dest_reg, output src1_reg, output src2_reg, output immediate,
                  output branch_target, input ready);
  modport sink (input valid, input legal, input operation, input size_code,
                input modifier_flags, input float_precisions, input operand_form,
                input dest_reg, input src1_reg, input src2_reg, input immediate,
                input branch_target, output ready);
endinterface

FILE: rtl/core/risc_instruction_decoder.sv
`timescale 1ns / 1ps
// Instruction decoder for a 32-bit RISC, three register stages.
// Uses rid_pkg, rid_in_if and rid_out_if.
//
// Usage:
//   instr   : one item is an instruction word and the address that follows it.
//   decoded : one item per input item, in order: legality flag, operation,
//             size, modifier flags, float precisions, operand form, registers,
//             immediate and branch target. An illegal word gives legal 0 and
//             all other fields 0.
//   Stage 1 registers the word, stage 2 holds the decoded fields and the
//   scaled displacement with next_address - 4, stage 3 adds the target and
//   drives the output channel.
//   The item is registered in stage 1, stage 2 and stage 3 in turn; decoded.valid
//   is the stage 3 valid bit.
//   Throughput: one item per cycle unless stalled; the three stages advance together.
//   A stalled receiver holds every stage; instr.ready drops while the
//   output item waits and is not taken. Nothing is dropped or repeated.
//   Reset clears all valid bits and holds instr.ready low; the block takes
//   an item in the next cycle.
module risc_instruction_decoder (
  input  logic       clk,
  input  logic       rst,
  rid_in_if.sink     instr,
  rid_out_if.source  decoded
);
  import rid_pkg::*;

  logic        adv;
  logic        s1_valid;
  logic [31:0] s1_word;
  logic [31:0] s1_next;
  logic        s2_valid;
  dec_t        s2_dec;
  logic [31:0] s2_base;
  logic        s3_valid;
  dec_t        s3_dec;
  logic [31:0] s3_target;

  assign adv = !s3_valid || decoded.ready;
  assign instr.ready = !rst && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= instr.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_word   <= instr.instruction_word;
      s1_next   <= instr.next_address;
      s2_dec    <= rid_decode(s1_word);
      s2_base   <= s1_next - 32'd4;
      s3_dec    <= s2_dec;
      s3_target <= s2_dec.tgt_en ? (s2_base + s2_dec.disp) : 32'd0;
    end
  end

  assign decoded.valid            = s3_valid;
  assign decoded.legal            = s3_dec.legal;
  assign decoded.operation        = s3_dec.operation;
  assign decoded.size_code        = s3_dec.size_code;
  assign decoded.modifier_flags   = s3_dec.modifier_flags;
  assign decoded.float_precisions = s3_dec.float_precisions;
  assign decoded.operand_form     = s3_dec.operand_form;
  assign decoded.dest_reg         = s3_dec.dest_reg;
  assign decoded.src1_reg         = s3_dec.src1_reg;
  assign decoded.src2_reg         = s3_dec.src2_reg;
  assign decoded.immediate        = s3_dec.immediate;
  assign decoded.branch_target    = s3_target;

`ifndef ASSERT_OFF
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_dec.legal) |-> (s3_dec.operation == 6'd0 && s3_dec.operand_form == 5'd0
      && s3_dec.modifier_flags == 8'd0 && s3_target == 32'd0 && s3_dec.immediate == 16'd0))
    else $error("illegal word with nonzero fields");

  a_target_form: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_dec.operand_form != FORM_BIT_DISP && s3_dec.operand_form != FORM_COND_DISP
      && s3_dec.operand_form != FORM_DISP26) |-> (s3_target == 32'd0))
    else $error("branch target on a non-branch form");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_dec.size_code <= SIZE_UHALF && s3_dec.operation <= OP_RTE))
    else $error("size or operation out of range");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid) |=> s3_valid)
    else $error("item lost between stage 2 and stage 3");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !decoded.ready) |=> (s2_valid == $past(s2_valid) && s1_valid == $past(s1_valid)))
    else $error("pipeline moved during stall");
`endif

endmodule

FILE: test/rid_decode_checker.sv
`timescale 1ns / 1ps
// Decode checker: watches the instr and decoded channels, predicts each decoded item and compares.
// Depends on rid_pkg, rid_in_if and rid_out_if.
module rid_decode_checker (
  input  logic clk,
  input  logic rst,
  rid_in_if    instr,
  rid_out_if   decoded,
  output int   failures,
  output int   outstanding
);
  import rid_pkg::*;

  typedef struct packed {
    logic        legal;
    logic [5:0]  operation;
    logic [2:0]  size_code;
    logic [7:0]  modifier_flags;
    logic [2:0]  float_precisions;
    logic [4:0]  operand_form;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [15:0] immediate;
    logic [31:0] branch_target;
  } decode_fields_t;

  decode_fields_t expected_decodes[$];

  function automatic logic [2:0] regs_of_form(input logic [4:0] form);
    logic [2:0] m;
    case (form)
      FORM_RD_RS1_IMM, FORM_BIT_DISP, FORM_COND_DISP, FORM_RD_RS1_CR, FORM_FIELD,
      FORM_BIT_VEC, FORM_COND_VEC: m = 3'b011;
      FORM_RD_RS1_RS2, FORM_RD_INDEX: m = 3'b111;
      FORM_RD_RS2: m = 3'b101;
      FORM_RS1_IMM, FORM_RS1_CR: m = 3'b010;
      FORM_RS1_RS2: m = 3'b110;
      FORM_RS2: m = 3'b100;
      FORM_RD_CR: m = 3'b001;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] branch_dest(input logic [31:0] nxt, input logic [25:0] disp,
                                              input logic long_disp);
    logic [31:0] ext;
    ext = long_disp ? {{6{disp[25]}}, disp} : {{16{disp[15]}}, disp[15:0]};
    return nxt - 32'd4 + (ext << 2);
  endfunction

  // {operation, size} of a load, store or exchange
  function automatic logic [8:0] mem_access(input logic [1:0] p, input logic [1:0] ty);
    logic [5:0] op;
    logic [2:0] sz;
    op = {4'd0, p};
    if (p == 2'd0 && ty[1]) begin
      op = OP_LD;
    end
    case ({p == 2'd0, ty})
      3'b000: sz = SIZE_DOUBLE;
      3'b010: sz = SIZE_HALF;
      3'b011: sz = SIZE_BYTE;
      3'b100, 3'b111: sz = SIZE_UBYTE;
      3'b110: sz = SIZE_UHALF;
      default: sz = SIZE_WORD;
    endcase
    return {op, sz};
  endfunction

  function automatic decode_fields_t decode_instruction(input logic [31:0] w,
                                                        input logic [31:0] nxt);
    decode_fields_t d;
    logic           ok;
    logic [2:0]     maj;
    logic [2:0]     mn;
    logic [2:0]     sub;
    logic [4:0]     rd;
    logic [4:0]     rs1;
    logic [4:0]     rs2;
    logic [4:0]     fo;
    logic [8:0]     ma;
    logic [2:0]     m;
    d   = '0;
    ok  = 1'b0;
    maj = w[31:29];
    mn  = w[28:26];
    rd  = w[25:21];
    rs1 = w[20:16];
    rs2 = w[4:0];
    fo  = w[15:11];
    case (maj)
      3'd0, 3'd1: begin
        ok = (w[29:28] != 2'd3);
        ma = mem_access(w[29:28], w[27:26]);
        {d.operation, d.size_code} = ma;
        d.operand_form = FORM_RD_RS1_IMM;
        d.immediate = w[15:0];
      end
      3'd2: begin
        ok = 1'b1;
        d.operation = OP_AND + {4'd0, mn[2:1]};
        if (mn[0]) d.modifier_flags = FLAG_U;
        d.operand_form = FORM_RD_RS1_IMM;
        d.immediate = w[15:0];
      end
      3'd3: begin
        ok = 1'b1;
        d.operation = OP_ADDU + {3'd0, mn};
        d.operand_form = FORM_RD_RS1_IMM;
        d.immediate = w[15:0];
      end
      3'd4: begin
        if (mn == 3'd0 && w[15:14] != 2'd0 && w[13:11] <= 3'd1) begin
          if (w[11]) d.modifier_flags = FLAG_FPU;
          d.immediate = {10'd0, w[10:5]};
          case (w[15:14])
            2'd1: begin
              ok = (rs1 == 5'd0) && (rs2 == 5'd0);
              d.operation = OP_LDCR;
              d.operand_form = FORM_RD_CR;
            end
            2'd2: begin
              ok = (rd == 5'd0);
              d.operation = OP_STCR;
              d.operand_form = FORM_RS1_CR;
            end
            default: begin
              ok = 1'b1;
              d.operation = OP_XCR;
              d.operand_form = FORM_RD_RS1_CR;
            end
          endcase
        end else if (mn == 3'd1 && !w[10] && !w[8] && !w[6]) begin
          d.float_precisions = {w[7], w[9], w[5]};
          d.operand_form = FORM_RD_RS1_RS2;
          case (fo)
            5'd0: begin ok = 1'b1; d.operation = OP_FMUL; end
            5'd5: begin ok = 1'b1; d.operation = OP_FADD; end
            5'd6: begin ok = 1'b1; d.operation = OP_FSUB; end
            5'd14: begin ok = 1'b1; d.operation = OP_FDIV; end
            5'd7: begin ok = !w[5]; d.operation = OP_FCMP; end
            5'd4: begin
              ok = !w[7] && rs1 == 5'd0 && !w[9];
              d.operation = OP_FLT;
              d.operand_form = FORM_RD_RS2;
            end
            5'd9, 5'd10, 5'd11: begin
              ok = !w[5] && rs1 == 5'd0 && !w[9];
              d.operation = OP_INT + {1'b0, fo} - 6'd9;
              d.operand_form = FORM_RD_RS2;
            end
            default: ok = 1'b0;
          endcase
        end
      end
      3'd6: begin
        ok = 1'b1;
        d.operation = OP_BR + {4'd0, mn[2:1]};
        if (mn[0]) d.modifier_flags = FLAG_N;
        if (mn[2]) begin
          d.operand_form = FORM_BIT_DISP;
          d.branch_target = branch_dest(nxt, w[25:0], 1'b0);
        end else begin
          d.operand_form = FORM_DISP26;
          d.branch_target = branch_dest(nxt, w[25:0], 1'b1);
        end
      end
      3'd7: begin
        case (mn)
          3'd2, 3'd3: begin
            ok = 1'b1;
            d.operation = OP_BCND;
            if (mn[0]) d.modifier_flags = FLAG_N;
            d.operand_form = FORM_COND_DISP;
            d.branch_target = branch_dest(nxt, w[25:0], 1'b0);
          end
          3'd4: begin
            d.immediate = {6'd0, w[9:0]};
            if (!w[10] && w[15:14] == 2'd2 && w[13:11] <= 3'd5) begin
              ok = 1'b1;
              d.operation = OP_CLR + {3'd0, w[13:11]};
              d.operand_form = FORM_FIELD;
            end else if (!w[10] && w[15:14] == 2'd3) begin
              ok = 1'b1;
              case (w[13:11])
                3'd2: begin d.operation = OP_TB0; d.operand_form = FORM_BIT_VEC; end
                3'd3: begin d.operation = OP_TB1; d.operand_form = FORM_BIT_VEC; end
                3'd5: begin d.operation = OP_TCND; d.operand_form = FORM_COND_VEC; end
                default: ok = 1'b0;
              endcase
            end
          end
          3'd5: begin
            case (w[15:13])
              3'd0, 3'd1: begin
                ok = !(w[13:12] == 2'd3 && (!w[9] || w[8])) && w[7:5] == 3'd0;
                ma = mem_access(w[13:12], w[11:10]);
                {d.operation, d.size_code} = ma;
                if (w[8]) d.modifier_flags |= FLAG_USER;
                if (w[9]) begin
                  d.modifier_flags |= FLAG_IDX;
                  d.operand_form = FORM_RD_INDEX;
                end else begin
                  d.operand_form = FORM_RD_RS1_RS2;
                end
              end
              3'd2: begin
                ok = w[9:5] == 5'd0 && w[12:11] != 2'd1;
                if (w[10]) d.modifier_flags = FLAG_C;
                d.operation = OP_AND + {4'd0, w[12:11]};
                d.operand_form = FORM_RD_RS1_RS2;
              end
              3'd3: begin
                sub = w[12:10];
                ok = w[7:5] == 3'd0;
                if (sub == 3'd2 || sub == 3'd3 || sub == 3'd6 || sub == 3'd7) begin
                  if (w[9]) ok = 1'b0;
                end else begin
                  if (w[9]) d.modifier_flags |= FLAG_CI;
                  if (w[8]) d.modifier_flags |= FLAG_CO;
                end
                d.operation = OP_ADDU + {3'd0, sub};
                d.operand_form = FORM_RD_RS1_RS2;
              end
              3'd4, 3'd5: begin
                ok = w[10:5] == 6'd0 && w[13:11] <= 3'd5;
                d.operation = OP_CLR + {3'd0, w[13:11]};
                d.operand_form = FORM_RD_RS1_RS2;
              end
              3'd6: begin
                ok = rd == 5'd0 && rs1 == 5'd0 && w[9:5] == 5'd0;
                d.operation = w[11] ? OP_JSR : OP_JMP;
                if (w[10]) d.modifier_flags = FLAG_N;
                d.operand_form = FORM_RS2;
              end
              default: begin
                sub = w[12:10];
                case (sub)
                  3'd2, 3'd3: begin
                    ok = rs1 == 5'd0;
                    d.operation = w[10] ? OP_FF0 : OP_FF1;
                    d.operand_form = FORM_RD_RS2;
                  end
                  3'd6: begin
                    ok = rd == 5'd0;
                    d.operation = OP_TBND;
                    d.operand_form = FORM_RS1_RS2;
                  end
                  3'd7: begin
                    ok = rd == 5'd0 && rs1 == 5'd0 && rs2 == 5'd0;
                    d.operation = OP_RTE;
                    d.operand_form = FORM_NONE;
                  end
                  default: ok = 1'b0;
                endcase
                if (w[9:5] != 5'd0) ok = 1'b0;
              end
            endcase
          end
          3'd6: begin
            ok = rd == 5'd0;
            d.operation = OP_TBND;
            d.operand_form = FORM_RS1_IMM;
            d.immediate = w[15:0];
          end
          default: ok = 1'b0;
        endcase
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      d = '0;
    end else begin
      m = regs_of_form(d.operand_form);
      d.legal = 1'b1;
      d.dest_reg = m[0] ? rd : 5'd0;
      d.src1_reg = m[1] ? rs1 : 5'd0;
      d.src2_reg = m[2] ? rs2 : 5'd0;
    end
    return d;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
      failures++;
    end
  endtask

  initial begin
    failures = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    decode_fields_t exp_d;
    if (!rst) begin
      if (instr.valid && instr.ready) begin
        expected_decodes.push_back(decode_instruction(instr.instruction_word,
                                                      instr.next_address));
      end
      if (decoded.valid && decoded.ready) begin
        if (expected_decodes.size() == 0) begin
          $display("%0t: decoded item with no instruction outstanding", $time);
          failures++;
        end else begin
          exp_d = expected_decodes.pop_front();
          check_field("legal", 32'(exp_d.legal), 32'(decoded.legal));
          check_field("operation", 32'(exp_d.operation), 32'(decoded.operation));
          check_field("size_code", 32'(exp_d.size_code), 32'(decoded.size_code));
          check_field("modifier_flags", 32'(exp_d.modifier_flags),
                      32'(decoded.modifier_flags));
          check_field("float_precisions", 32'(exp_d.float_precisions),
                      32'(decoded.float_precisions));
          check_field("operand_form", 32'(exp_d.operand_form), 32'(decoded.operand_form));
          check_field("dest_reg", 32'(exp_d.dest_reg), 32'(decoded.dest_reg));
          check_field("src1_reg", 32'(exp_d.src1_reg), 32'(decoded.src1_reg));
          check_field("src2_reg", 32'(exp_d.src2_reg), 32'(decoded.src2_reg));
          check_field("immediate", 32'(exp_d.immediate), 32'(decoded.immediate));
          check_field("branch_target", exp_d.branch_target, decoded.branch_target);
        end
      end
      outstanding = expected_decodes.size();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the instruction decoder bench: clock, reset, instruction stimulus and the verdict.
// Depends on rid_pkg, rid_in_if, rid_out_if, rid_decode_checker and risc_instruction_decoder.
module tb_top;

  localparam logic [44:0] FLOAT_CODES = {5'd0, 5'd4, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10,
                                         5'd11, 5'd14};

  logic clk;
  logic rst;
  logic calm;
  int   failures;
  int   outstanding;

  rid_in_if  instr_ch ();
  rid_out_if decoded_ch ();

  risc_instruction_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr_ch),
    .decoded (decoded_ch)
  );

  rid_decode_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .instr       (instr_ch),
    .decoded     (decoded_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    decoded_ch.ready = calm || ($urandom_range(0, 99) >= 38);
  end

  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 2) == 0) w[25:21] = 5'd0;
    if ($urandom_range(0, 2) == 0) w[20:16] = 5'd0;
    if ($urandom_range(0, 2) == 0) w[4:0] = 5'd0;
    case ($urandom_range(0, 11))
      0: ;
      1: begin
        w[31:26] = 6'b100000;
        if ($urandom_range(0, 3) != 0) w[13:12] = 2'd0;
      end
      2: begin
        w[31:26] = 6'b100001;
        if ($urandom_range(0, 3) != 0) begin
          w[10] = 1'b0;
          w[8] = 1'b0;
          w[6] = 1'b0;
        end
        if ($urandom_range(0, 3) != 0) w[15:11] = FLOAT_CODES[5 * $urandom_range(0, 8) +: 5];
      end
      3: begin
        w[31:26] = 6'b111100;
        if ($urandom_range(0, 3) != 0) w[10] = 1'b0;
        if ($urandom_range(0, 3) != 0) w[15] = 1'b1;
      end
      5: begin
        w[31:26] = 6'b111110;
        if ($urandom_range(0, 3) != 0) w[25:21] = 5'd0;
      end
      6: w[31:27] = 5'b11101;
      7: w[31:29] = 3'b110;
      8: w[31:29] = 3'($urandom_range(0, 3));
      9: w[31:29] = 3'($urandom_range(4, 7));
      default: begin
        w[31:26] = 6'b111101;
        if ($urandom_range(0, 3) != 0) w[7:5] = 3'd0;
        if (w[15:14] != 2'd0 && $urandom_range(0, 2) != 0) w[9:8] = 2'd0;
        if (w[15:14] == 2'd2 && $urandom_range(0, 2) != 0) w[10] = 1'b0;
        if (w[15:14] == 2'd3 && $urandom_range(0, 1) != 0) begin
          w[25:16] = 10'd0;
          w[11] = 1'b1;
          if ($urandom_range(0, 1) != 0) w[4:0] = 5'd0;
        end
      end
    endcase
    return w;
  endfunction

  function automatic logic [31:0] random_address();
    logic [31:0] a;
    case ($urandom_range(0, 7))
      0: a = 32'h0000_0000;
      1: a = 32'hFFFF_FFFC;
      default: a = $urandom;
    endcase
    return a;
  endfunction

  task automatic send_instruction(input logic [31:0] w, input logic [31:0] nxt);
    if (!calm) begin
      while ($urandom_range(0, 99) < 38) begin
        instr_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    instr_ch.valid = 1'b1;
    instr_ch.instruction_word = w;
    instr_ch.next_address = nxt;
    do @(posedge clk); while (!instr_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("risc_instruction_decoder verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    instr_ch.valid = 1'b0;
    instr_ch.instruction_word = 32'd0;
    instr_ch.next_address = 32'd0;
    decoded_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_instruction(32'h0000_0000, 32'h0000_0000);
    send_instruction(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instruction(32'h0843_8000, 32'h1234_5678);
    send_instruction(32'h0400_0001, 32'h0000_0100);
    send_instruction(32'h3000_0000, 32'h0000_0100);
    send_instruction(32'h47FF_FFFF, 32'h0000_0100);
    send_instruction(32'hC3FF_FFFF, 32'h0000_0000);
    send_instruction(32'hCE00_0000, 32'h0000_0004);
    send_instruction(32'hDC00_7FFF, 32'hFFFF_FFFC);
    send_instruction(32'hEC00_8000, 32'h0000_1000);
    send_instruction(32'h80A0_4FE0, 32'h0000_0000);
    send_instruction(32'h8007_805F, 32'h0000_0000);
    send_instruction(32'h8021_C020, 32'h0000_0000);
    send_instruction(32'h8400_7800, 32'h0000_0000);
    send_instruction(32'h8400_3820, 32'h0000_0000);
    send_instruction(32'h8464_2AA5, 32'h0000_0000);
    send_instruction(32'h8440_5889, 32'h0000_0000);
    send_instruction(32'h8400_2080, 32'h0000_0000);
    send_instruction(32'hF3FF_93FF, 32'h0000_0000);
    send_instruction(32'hF040_EBFF, 32'h0000_0000);
    send_instruction(32'hF400_3300, 32'h0000_0000);
    send_instruction(32'hF442_3605, 32'h0000_0000);
    send_instruction(32'hF400_0D00, 32'h0000_0000);
    send_instruction(32'hF400_6A00, 32'h0000_0000);
    send_instruction(32'hF400_6300, 32'h0000_0000);
    send_instruction(32'hF400_6D00, 32'h0000_0000);
    send_instruction(32'hF400_CC01, 32'h0000_0000);
    send_instruction(32'hF400_FC00, 32'h0000_0000);
    send_instruction(32'hF81F_FFFF, 32'h0000_0000);
    send_instruction(32'hA000_0000, 32'h0000_0000);

    for (int i = 0; i < 1250; i++) begin
      calm = (i >= 500 && i < 700);
      send_instruction(random_instruction(), random_address());
    end
    calm = 1'b0;
    instr_ch.valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("risc_instruction_decoder verification clean");
    end else begin
      $display("risc_instruction_decoder verification failed");
    end
    $finish;
  end

endmodule
